FILE: hw/rtl/kmd_pkg.sv
package kmd_pkg;

    localparam int ROW_COUNT_DEF = 4;
    localparam int COL_COUNT_DEF = 3;

    localparam int ROW_W     = 2;
    localparam int PORT_W    = 8;
    localparam int CNT_W     = 4;
    localparam int CODE_W    = 4;
    localparam int MAP_W     = 12;
    localparam int CFG_IDX_W = 4;
    localparam int COL_BASE  = 4;

    localparam logic [CNT_W-1:0] PRESS_THR_RST   = CNT_W'(5);
    localparam logic [CNT_W-1:0] RELEASE_THR_RST = CNT_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_THRESHOLD   = CFG_IDX_W'(0),
        CFG_RELEASE_THRESHOLD = CFG_IDX_W'(1)
    } t_cfg_index;

    typedef struct packed {
        logic valid;
        logic last;
    } t_scan_status;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

FILE: hw/rtl/kmd_ram.sv
module kmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = kmd_pkg::addr_bits(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/kmd_scan.sv
module kmd_scan #(
    parameter int ROW_COUNT = kmd_pkg::ROW_COUNT_DEF,
    parameter int COL_COUNT = kmd_pkg::COL_COUNT_DEF,
    localparam int KEY_COUNT = ROW_COUNT * COL_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_accept,
    input  logic [kmd_pkg::ROW_W-1:0]  i_row,
    input  logic [kmd_pkg::PORT_W-1:0] i_port_byte,
    input  logic [kmd_pkg::CNT_W-1:0]  i_press_thr,
    input  logic [kmd_pkg::CNT_W-1:0]  i_release_thr,
    output logic [KEY_COUNT-1:0]       o_key_down,
    output kmd_pkg::t_scan_status      o_status
);

    localparam int AW    = kmd_pkg::addr_bits(ROW_COUNT);
    localparam int CW    = kmd_pkg::CNT_W;
    localparam int WIDTH = COL_COUNT * CW;

    logic                 in_range;
    logic                 in_last;
    logic [COL_COUNT-1:0] in_low;
    logic [AW-1:0]        rd_addr;
    logic [WIDTH-1:0]     rd_data;

    logic                 r_s1_valid;
    logic                 r_s1_last;
    logic [AW-1:0]        r_s1_addr;
    logic [COL_COUNT-1:0] r_s1_low;

    logic                 r_fwd_valid;
    logic [AW-1:0]        r_fwd_addr;
    logic [WIDTH-1:0]     r_fwd_data;

    logic [ROW_COUNT-1:0] r_row_vld;
    logic [KEY_COUNT-1:0] r_key_down;
    logic [KEY_COUNT-1:0] n_key_down;
    kmd_pkg::t_scan_status r_status;

    logic                 wr_en;
    logic [WIDTH-1:0]     base;
    logic [WIDTH-1:0]     wr_data;

    assign in_range = int'(i_row) < ROW_COUNT;
    assign in_last  = int'(i_row) == (ROW_COUNT - 1);
    assign rd_addr  = AW'(i_row);

    always_comb begin
        for (int c = 0; c < COL_COUNT; c++) begin
            if (kmd_pkg::COL_BASE + c < kmd_pkg::PORT_W) begin
                in_low[c] = ~i_port_byte[(kmd_pkg::COL_BASE + c) % kmd_pkg::PORT_W];
            end else begin
                in_low[c] = 1'b0;
            end
        end
    end

    kmd_ram #(
        .WIDTH (WIDTH),
        .DEPTH (ROW_COUNT)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_data),
        .i_re    (i_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign wr_en = i_en && r_s1_valid;

    always_comb begin
        logic [CW-1:0] cnt;
        int            k;
        cnt = '0;
        k   = 0;
        if (r_fwd_valid && r_fwd_addr == r_s1_addr) begin
            base = r_fwd_data;
        end else if (r_row_vld[r_s1_addr]) begin
            base = rd_data;
        end else begin
            base = '0;
        end
        n_key_down = r_key_down;
        wr_data    = base;
        for (int c = 0; c < COL_COUNT; c++) begin
            cnt = base[c*CW +: CW];
            if (r_s1_low[c]) begin
                if (cnt < i_press_thr) begin
                    cnt = cnt + CW'(1);
                end
            end else if (cnt != '0) begin
                cnt = cnt - CW'(1);
            end
            wr_data[c*CW +: CW] = cnt;
            k = int'(r_s1_addr) * COL_COUNT + c;
            if (cnt >= i_press_thr) begin
                n_key_down[k] = 1'b1;
            end else if (cnt <= i_release_thr) begin
                n_key_down[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_row_vld   <= '0;
            r_key_down  <= '0;
            r_status    <= '0;
        end else if (i_en) begin
            r_s1_valid      <= i_accept && in_range;
            r_fwd_valid     <= wr_en;
            r_status.valid  <= r_s1_valid;
            r_status.last   <= r_s1_last;
            if (wr_en) begin
                r_row_vld[r_s1_addr] <= 1'b1;
                r_key_down           <= n_key_down;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_last  <= in_last;
            r_s1_addr  <= rd_addr;
            r_s1_low   <= in_low;
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= wr_data;
        end
    end

    assign o_key_down = r_key_down;
    assign o_status   = r_status;

    a_row_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_row_vld[$past(r_s1_addr)])
        else $error("written row not marked valid");

    a_stall_holds_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_key_down))
        else $error("key flags changed during stall");

endmodule

FILE: hw/rtl/kmd_report.sv
module kmd_report #(
    parameter int ROW_COUNT = kmd_pkg::ROW_COUNT_DEF,
    parameter int COL_COUNT = kmd_pkg::COL_COUNT_DEF,
    localparam int KEY_COUNT = ROW_COUNT * COL_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  kmd_pkg::t_scan_status      i_status,
    input  logic [KEY_COUNT-1:0]       i_key_down,
    output logic                       o_valid,
    output logic                       o_event_res,
    output logic [kmd_pkg::CODE_W-1:0] o_key_code,
    output logic [kmd_pkg::MAP_W-1:0]  o_pressed_map
);

    logic [KEY_COUNT-1:0]       r_reported;
    logic [KEY_COUNT-1:0]       n_reported;
    logic                       found;
    logic [kmd_pkg::CODE_W-1:0] code;
    logic [kmd_pkg::MAP_W-1:0]  map;
    logic                       do_report;

    logic                       r_valid;
    logic                       r_event_res;
    logic [kmd_pkg::CODE_W-1:0] r_key_code;
    logic [kmd_pkg::MAP_W-1:0]  r_pressed_map;

    assign do_report = i_status.valid && i_status.last;

    // first unreported press wins; marks below it follow the key state
    always_comb begin
        n_reported = r_reported;
        found      = 1'b0;
        code       = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (!found) begin
                if (i_key_down[k] && !r_reported[k]) begin
                    n_reported[k] = 1'b1;
                    found         = 1'b1;
                    code          = kmd_pkg::CODE_W'(k + 1);
                end else if (!i_key_down[k] && r_reported[k]) begin
                    n_reported[k] = 1'b0;
                end
            end
        end
        map = '0;
        for (int k = 0; k < kmd_pkg::MAP_W; k++) begin
            if (k < KEY_COUNT) begin
                map[k] = i_key_down[k % KEY_COUNT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_reported <= '0;
        end else if (i_en) begin
            r_valid <= do_report;
            if (do_report) begin
                r_reported <= n_reported;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && do_report) begin
            r_event_res   <= found;
            r_key_code    <= code;
            r_pressed_map <= map;
        end
    end

    assign o_valid       = r_valid;
    assign o_event_res   = r_event_res;
    assign o_key_code    = r_key_code;
    assign o_pressed_map = r_pressed_map;

    a_report_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && do_report) |=> r_valid)
        else $error("last row did not produce a result");

    a_event_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_event_res) |-> (r_key_code != '0))
        else $error("event without key code");

    a_no_event_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_event_res) |-> (r_key_code == '0))
        else $error("key code without event");

endmodule

FILE: hw/rtl/keypad_matrix_debouncer.sv
// Keypad matrix debouncer.
// Input channel (i_valid/o_ready): one transaction per scanned row, carrying
// the row number and the raw port byte; bits 4 and up are active-low columns.
// Config channel (i_cfg_valid/o_cfg_ready): index 0 press threshold,
// index 1 release threshold; always ready, write only while idle.
// Output channel (o_valid/i_ready): one transaction per last-row scan, with
// event flag, key code of the first new press and the debounced pressed map.
// Throughput: one row per cycle if not stalled; counter RAM does one row read
// and one row write per cycle, back-to-back rows to the same row are forwarded.
// Result path: a last row passes the stage 1, status and report registers.
// Stall: while a result waits on i_ready the whole pipeline holds and o_ready
// is low; the result moves out in the cycle it is taken and a new row is
// accepted in that same cycle.
// Reset: thresholds return to 5 and 2; all counters, pressed flags and report
// marks read as zero at once (per-row valid bits, no clearing pass).
module keypad_matrix_debouncer #(
    parameter int ROW_COUNT = kmd_pkg::ROW_COUNT_DEF,
    parameter int COL_COUNT = kmd_pkg::COL_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kmd_pkg::ROW_W-1:0]     i_row,
    input  logic [kmd_pkg::PORT_W-1:0]    i_port_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_event_res,
    output logic [kmd_pkg::CODE_W-1:0]    o_key_code,
    output logic [kmd_pkg::MAP_W-1:0]     o_pressed_map,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kmd_pkg::CNT_W-1:0]     i_cfg_data
);

    localparam int KEY_COUNT = ROW_COUNT * COL_COUNT;

    logic                      en;
    logic                      accept;
    logic [kmd_pkg::CNT_W-1:0] r_press_thr;
    logic [kmd_pkg::CNT_W-1:0] r_release_thr;
    logic [KEY_COUNT-1:0]      key_down;
    kmd_pkg::t_scan_status     status;

    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign accept      = i_valid && en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_thr   <= kmd_pkg::PRESS_THR_RST;
            r_release_thr <= kmd_pkg::RELEASE_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kmd_pkg::CFG_PRESS_THRESHOLD:   r_press_thr   <= i_cfg_data;
                kmd_pkg::CFG_RELEASE_THRESHOLD: r_release_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kmd_scan #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_accept      (accept),
        .i_row         (i_row),
        .i_port_byte   (i_port_byte),
        .i_press_thr   (r_press_thr),
        .i_release_thr (r_release_thr),
        .o_key_down    (key_down),
        .o_status      (status)
    );

    kmd_report #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_report (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_status      (status),
        .i_key_down    (key_down),
        .o_valid       (o_valid),
        .o_event_res   (o_event_res),
        .o_key_code    (o_key_code),
        .o_pressed_map (o_pressed_map)
    );

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kmd_pkg::*;

    localparam int KEYS         = ROW_COUNT_DEF * COL_COUNT_DEF;
    localparam int LAST_ROW     = ROW_COUNT_DEF - 1;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic              event_res;
        logic [CODE_W-1:0] key_code;
        logic [MAP_W-1:0]  pressed_map;
    } scan_report_t;

    class keypad_predictor;
        logic [CNT_W-1:0] press_thr;
        logic [CNT_W-1:0] release_thr;
        logic [CNT_W-1:0] level[KEYS];
        bit               down[KEYS];
        bit               reported[KEYS];
        scan_report_t     expected_scans[$];
        int               errors;

        function void clear();
            press_thr   = PRESS_THR_RST;
            release_thr = RELEASE_THR_RST;
            errors      = 0;
            for (int k = 0; k < KEYS; k++) begin
                level[k]    = '0;
                down[k]     = 1'b0;
                reported[k] = 1'b0;
            end
        endfunction

        function void set_reg(t_cfg_index idx, logic [CNT_W-1:0] val);
            case (idx)
                CFG_PRESS_THRESHOLD: begin
                    press_thr = val;
                end
                CFG_RELEASE_THRESHOLD: begin
                    release_thr = val;
                end
                default: begin
                end
            endcase
        endfunction

        // integrate one row; on the last row build the scan report
        function void note_row(logic [ROW_W-1:0] row, logic [PORT_W-1:0] port);
            int           k;
            scan_report_t rpt;
            for (int c = 0; c < COL_COUNT_DEF; c++) begin
                k = int'(row) * COL_COUNT_DEF + c;
                if (!port[COL_BASE+c]) begin
                    if (level[k] < press_thr)
                        level[k] = level[k] + 1'b1;
                end else if (level[k] != '0) begin
                    level[k] = level[k] - 1'b1;
                end
                if (level[k] >= press_thr)
                    down[k] = 1'b1;
                else if (level[k] <= release_thr)
                    down[k] = 1'b0;
            end
            if (int'(row) != LAST_ROW)
                return;
            rpt = '0;
            for (k = 0; k < KEYS; k++) begin
                if (down[k] && !reported[k]) begin
                    reported[k]   = 1'b1;
                    rpt.event_res = 1'b1;
                    rpt.key_code  = CODE_W'(k + 1);
                    break;
                end else if (!down[k] && reported[k]) begin
                    reported[k] = 1'b0;
                end
            end
            for (k = 0; k < KEYS && k < MAP_W; k++)
                rpt.pressed_map[k] = down[k];
            expected_scans.push_back(rpt);
        endfunction

        function void check_scan(logic ev, logic [CODE_W-1:0] code, logic [MAP_W-1:0] map);
            scan_report_t want;
            if (expected_scans.size() == 0) begin
                $error("unexpected scan report: event_res=%0b key_code=%0d pressed_map=%h",
                       ev, code, map);
                errors++;
                return;
            end
            want = expected_scans.pop_front();
            if (ev !== want.event_res) begin
                $error("event_res: expected %0b, got %0b", want.event_res, ev);
                errors++;
            end
            if (code !== want.key_code) begin
                $error("key_code: expected %0d, got %0d", want.key_code, code);
                errors++;
            end
            if (map !== want.pressed_map) begin
                $error("pressed_map: expected %h, got %h", want.pressed_map, map);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [ROW_W-1:0]     i_row       = '0;
    logic [PORT_W-1:0]    i_port_byte = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic                 o_event_res;
    logic [CODE_W-1:0]    o_key_code;
    logic [MAP_W-1:0]     o_pressed_map;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_PRESS_THRESHOLD;
    logic [CNT_W-1:0]     i_cfg_data  = '0;

    keypad_predictor scans;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    logic            holding        = 1'b0;
    int              cycles         = 0;
    event            hold_go;

    keypad_matrix_debouncer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_row         (i_row),
        .i_port_byte   (i_port_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_event_res   (o_event_res),
        .o_key_code    (o_key_code),
        .o_pressed_map (o_pressed_map),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            scans.check_scan(o_event_res, o_key_code, o_pressed_map);
        i_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off so the pipeline backs up into o_ready
    initial begin
        forever begin
            @(hold_go);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic send_row(logic [ROW_W-1:0] row, logic [PORT_W-1:0] port);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_row       <= row;
        i_port_byte <= port;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        scans.note_row(row, port);
    endtask

    task automatic program_thresholds(logic [CNT_W-1:0] press, logic [CNT_W-1:0] release_lvl);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PRESS_THRESHOLD;
        i_cfg_data  <= press;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        scans.set_reg(CFG_PRESS_THRESHOLD, press);
        i_cfg_index <= CFG_RELEASE_THRESHOLD;
        i_cfg_data  <= release_lvl;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        scans.set_reg(CFG_RELEASE_THRESHOLD, release_lvl);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (scans.expected_scans.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly full scans of a slowly changing key pattern with contact bounce,
    // mixed with stray rows
    task automatic random_traffic(int n_items);
        logic [KEYS-1:0]   held;
        logic [PORT_W-1:0] port;
        int                sent;
        int                pick;
        held = '0;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_row(ROW_W'($urandom_range(ROW_COUNT_DEF - 1)), PORT_W'($urandom_range(255)));
                sent++;
            end else begin
                if ($urandom_range(99) < 30) begin
                    pick       = $urandom_range(KEYS - 1);
                    held[pick] = ~held[pick];
                end
                for (int r = 0; r < ROW_COUNT_DEF; r++) begin
                    port = PORT_W'($urandom_range(255));
                    for (int c = 0; c < COL_COUNT_DEF; c++)
                        port[COL_BASE+c] = ~held[r*COL_COUNT_DEF+c];
                    if ($urandom_range(99) < 8) begin
                        pick                = COL_BASE + $urandom_range(COL_COUNT_DEF - 1);
                        port[pick]          = ~port[pick];
                    end
                    send_row(ROW_W'(r), port);
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(int press, int release_lvl, int idle_pct, int stall_pct,
                             int n_items, bit backpressure);
        drain();
        program_thresholds(CNT_W'(press), CNT_W'(release_lvl));
        send_idle_pct  = idle_pct;
        recv_stall_pct <= stall_pct;
        if (backpressure)
            -> hold_go;
        random_traffic(n_items);
    endtask

    initial begin
        scans = new();
        scans.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds: all keys held for five scans, then all released
        for (int s = 0; s < 5; s++)
            for (int r = 0; r < ROW_COUNT_DEF; r++)
                send_row(ROW_W'(r), (r % 2) ? 8'h8F : 8'h00);
        for (int r = 0; r < ROW_COUNT_DEF; r++)
            send_row(ROW_W'(r), 8'hFF);

        run_phase(5,  2,  0,  0,  80, 1'b0);
        run_phase(1,  0,  82, 0,  70, 1'b0);
        run_phase(15, 14, 0,  82, 90, 1'b0);
        run_phase(15, 0,  20, 20, 80, 1'b0);
        // zero press threshold: every key reads as down
        run_phase(0,  0,  0,  0,  40, 1'b0);
        // release threshold above press threshold
        run_phase(3,  7,  82, 0,  60, 1'b0);
        run_phase(8,  3,  0,  82, 70, 1'b0);
        run_phase(2,  1,  20, 20, 70, 1'b0);
        run_phase(5,  2,  0,  0,  48, 1'b1);
        drain();

        if (scans.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
